@@ rtl/core/jpeg_block_entropy_decoder_top_defines.svh @@
// Assertion macros for the block entropy decoder checker.
// No dependencies; included by the checker file.
`ifndef JPEG_BLOCK_ENTROPY_DECODER_TOP_DEFINES_SVH
`define JPEG_BLOCK_ENTROPY_DECODER_TOP_DEFINES_SVH

// same-cycle implication, reset disables
`define JBED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define JBED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/jbed_pkg.sv @@
// Shared types and constants for the block entropy decoder.
// No dependencies.
package jbed_pkg;
	localparam int MAX_SYMBOLS     = 256;
	localparam int MAX_CODE_LENGTH = 16;
	localparam int BLOCK_COEFFS    = 64;
	localparam int QUEUE_DEPTH     = 4;
	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [7:0] SYM_ZRL = 8'hF0;

	typedef enum logic [1:0] {
		REQ_BIT     = 2'd0,
		REQ_COUNT   = 2'd1,
		REQ_SYMBOL  = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_DC_CODE = 2'd0,
		PH_DC_MAG  = 2'd1,
		PH_AC_CODE = 2'd2,
		PH_AC_MAG  = 2'd3
	} phase_t;

	typedef enum logic {
		FS_RUN    = 1'b0,
		FS_LOOKUP = 1'b1
	} fstate_t;

	// one queued command: a zero run starting at idx, then an optional value
	typedef struct packed {
		logic [5:0]  idx;
		logic [6:0]  zeros;
		logic        has_val;
		logic [15:0] val;
		logic        bad;
	} cmd_t;
endpackage

@@ rtl/core/jbed_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jbed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/jbed_queue.sv @@
// Short command queue between decode front and coefficient back end.
// Depends on jbed_pkg.
module jbed_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jbed_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          avail,
	output jbed_pkg::cmd_t head
);
	import jbed_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [PW:0]    cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop && avail) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && avail);
		end
	end
endmodule

@@ rtl/core/jbed_front.sv @@
// Decode front: takes words, loads tables, walks canonical Huffman codes
// and magnitude bits, and issues coefficient commands. Depends on jbed_pkg, jbed_ram.
module jbed_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     req_type,
	input  logic           table_sel,
	input  logic [7:0]     entry_index,
	input  logic [7:0]     entry_value,
	input  logic           data_bit,
	input  logic           q_full,
	output logic           push,
	output jbed_pkg::cmd_t push_cmd
);
	import jbed_pkg::*;

	fstate_t      fst_q, fst_d;
	phase_t       phase_q, phase_d;
	logic [15:0]  pred_q, pred_d;
	logic [6:0]   pos_q, pos_d;
	logic [15:0]  acc_q, acc_d;
	logic [4:0]   len_q, len_d;
	logic [16:0]  first_q, first_d;
	logic [8:0]   base_q, base_d;
	logic [15:0]  mbits_q, mbits_d;
	logic [3:0]   mleft_q, mleft_d;
	logic [3:0]   msize_q, msize_d;
	logic [7:0]   counts_q [2][MAX_CODE_LENGTH];

	logic         acc_word;
	logic         tsel;
	logic [15:0]  acc_n;
	logic [7:0]   cnt;
	logic [17:0]  off;
	logic [9:0]   pos_sym;
	logic [18:0]  first_n;
	logic [9:0]   base_n;
	logic [15:0]  mb_n;
	logic [15:0]  kval;
	logic         ram_re;
	logic [8:0]   ram_raddr;
	logic [7:0]   sym;
	logic [4:0]   run;
	logic [3:0]   mag;
	logic [6:0]   rem;
	logic [6:0]   zrun;

	jbed_ram #(.WIDTH(8), .DEPTH(2 * MAX_SYMBOLS)) u_sym_ram (
		.clk   (clk),
		.we    (acc_word && req_t'(req_type) == REQ_SYMBOL),
		.waddr ({table_sel, entry_index}),
		.wdata (entry_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (sym)
	);

	assign in_ready = (fst_q == FS_RUN) && !q_full;
	assign acc_word = in_valid && in_ready;
	assign tsel     = (phase_q != PH_DC_CODE);
	assign acc_n    = {acc_q[14:0], data_bit};
	assign cnt      = counts_q[tsel][len_q[3:0]];
	assign off      = {2'b0, acc_n} - {1'b0, first_q};
	assign pos_sym  = {1'b0, base_q} + {2'b0, off[7:0]};
	assign first_n  = {({1'b0, first_q} + {10'b0, cnt}), 1'b0};
	assign base_n   = {1'b0, base_q} + {2'b0, cnt};
	assign mb_n     = {mbits_q[14:0], data_bit};
	assign ram_raddr = {tsel, pos_sym[7:0]};

	always_comb begin
		if (mb_n[msize_q - 4'd1]) begin
			kval = mb_n;
		end else begin
			kval = mb_n - (16'd1 << msize_q) + 16'd1;
		end
	end

	always_comb begin
		run  = (sym == SYM_ZRL) ? 5'd16 : {1'b0, sym[7:4]};
		mag  = (sym == SYM_ZRL) ? 4'd0 : sym[3:0];
		rem  = 7'(BLOCK_COEFFS) - pos_q;
		zrun = ({2'b0, run} < rem) ? {2'b0, run} : rem;
	end

	always_comb begin
		fst_d    = fst_q;
		phase_d  = phase_q;
		pred_d   = pred_q;
		pos_d    = pos_q;
		acc_d    = acc_q;
		len_d    = len_q;
		first_d  = first_q;
		base_d   = base_q;
		mbits_d  = mbits_q;
		mleft_d  = mleft_q;
		msize_d  = msize_q;
		push     = 1'b0;
		push_cmd = '{idx: pos_q[5:0], zeros: 7'd0, has_val: 1'b1, val: 16'd0, bad: 1'b0};
		ram_re   = 1'b0;
		unique case (fst_q)
			FS_RUN: begin
				if (acc_word && req_t'(req_type) == REQ_RESTART) begin
					pred_d  = '0;
					pos_d   = '0;
					phase_d = PH_DC_CODE;
					acc_d   = '0;
					len_d   = '0;
					first_d = '0;
					base_d  = '0;
					mbits_d = '0;
					mleft_d = '0;
					msize_d = '0;
				end else if (acc_word && req_t'(req_type) == REQ_BIT) begin
					if (phase_q == PH_DC_MAG || phase_q == PH_AC_MAG) begin
						mbits_d = mb_n;
						mleft_d = mleft_q - 4'd1;
						if (mleft_q == 4'd1) begin
							push    = 1'b1;
							pos_d   = pos_q + 7'd1;
							phase_d = PH_AC_CODE;
							acc_d   = '0;
							len_d   = '0;
							first_d = '0;
							base_d  = '0;
							if (phase_q == PH_DC_MAG) begin
								pred_d       = pred_q + kval;
								push_cmd.val = pred_q + kval;
							end else begin
								push_cmd.val = kval;
								if (pos_q == 7'(BLOCK_COEFFS - 1)) begin
									pos_d   = '0;
									phase_d = PH_DC_CODE;
									mbits_d = '0;
									mleft_d = '0;
									msize_d = '0;
								end
							end
						end
					end else begin
						acc_d = acc_n;
						len_d = len_q + 5'd1;
						if (!off[17] && off[16:0] < {9'd0, cnt}) begin
							if (pos_sym >= 10'(MAX_SYMBOLS)) begin
								push         = 1'b1;
								push_cmd.bad = 1'b1;
								pos_d   = '0;
								phase_d = PH_DC_CODE;
								acc_d   = '0;
								len_d   = '0;
								first_d = '0;
								base_d  = '0;
								mbits_d = '0;
								mleft_d = '0;
								msize_d = '0;
							end else begin
								ram_re = 1'b1;
								fst_d  = FS_LOOKUP;
							end
						end else if (len_q + 5'd1 >= 5'(MAX_CODE_LENGTH)) begin
							push         = 1'b1;
							push_cmd.bad = 1'b1;
							pos_d   = '0;
							phase_d = PH_DC_CODE;
							acc_d   = '0;
							len_d   = '0;
							first_d = '0;
							base_d  = '0;
							mbits_d = '0;
							mleft_d = '0;
							msize_d = '0;
						end else begin
							first_d = (first_n > 19'h1FFFF) ? 17'h1FFFF : first_n[16:0];
							base_d  = (base_n > 10'd511) ? 9'd511 : base_n[8:0];
						end
					end
				end
			end
			FS_LOOKUP: begin
				if (!q_full) begin
					fst_d   = FS_RUN;
					acc_d   = '0;
					len_d   = '0;
					first_d = '0;
					base_d  = '0;
					if (phase_q == PH_DC_CODE) begin
						if (sym[3:0] == 4'd0) begin
							push         = 1'b1;
							push_cmd.val = pred_q;
							pos_d        = pos_q + 7'd1;
							phase_d      = PH_AC_CODE;
						end else begin
							msize_d = sym[3:0];
							mleft_d = sym[3:0];
							mbits_d = '0;
							phase_d = PH_DC_MAG;
						end
					end else if (sym == SYM_EOB) begin
						push             = 1'b1;
						push_cmd.zeros   = rem;
						push_cmd.has_val = 1'b0;
						pos_d   = '0;
						phase_d = PH_DC_CODE;
						mbits_d = '0;
						mleft_d = '0;
						msize_d = '0;
					end else begin
						push             = (zrun != 7'd0);
						push_cmd.zeros   = zrun;
						push_cmd.has_val = 1'b0;
						pos_d            = pos_q + zrun;
						if (zrun == rem) begin
							pos_d   = '0;
							phase_d = PH_DC_CODE;
							mbits_d = '0;
							mleft_d = '0;
							msize_d = '0;
						end else if (mag != 4'd0) begin
							msize_d = mag;
							mleft_d = mag;
							mbits_d = '0;
							phase_d = PH_AC_MAG;
						end
					end
				end
			end
			default: fst_d = FS_RUN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_word && req_t'(req_type) == REQ_COUNT && entry_index < 8'(MAX_CODE_LENGTH)) begin
			counts_q[table_sel][entry_index[3:0]] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q   <= FS_RUN;
			phase_q <= PH_DC_CODE;
			pred_q  <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
			len_q   <= '0;
			first_q <= '0;
			base_q  <= '0;
			mbits_q <= '0;
			mleft_q <= '0;
			msize_q <= '0;
		end else begin
			fst_q   <= fst_d;
			phase_q <= phase_d;
			pred_q  <= pred_d;
			pos_q   <= pos_d;
			acc_q   <= acc_d;
			len_q   <= len_d;
			first_q <= first_d;
			base_q  <= base_d;
			mbits_q <= mbits_d;
			mleft_q <= mleft_d;
			msize_q <= msize_d;
		end
	end
endmodule

@@ rtl/core/jbed_back.sv @@
// Coefficient back end: expands queued commands into result words
// through an output register. Depends on jbed_pkg.
module jbed_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_avail,
	input  jbed_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [5:0]     coef_index,
	output logic signed [15:0] coef_value,
	output logic           last_in_block,
	output logic           bad_code
);
	import jbed_pkg::*;

	cmd_t cur_q;
	logic busy_q;
	logic ovalid_q;
	logic adv;

	assign out_valid = ovalid_q;
	assign adv       = !ovalid_q || out_ready;
	assign q_pop     = !busy_q && q_avail;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end else if (busy_q && adv) begin
			if (cur_q.zeros != 7'd0) begin
				cur_q.zeros <= cur_q.zeros - 7'd1;
				cur_q.idx   <= cur_q.idx + 6'd1;
				coef_index    <= cur_q.idx;
				coef_value    <= '0;
				last_in_block <= (cur_q.idx == 6'(BLOCK_COEFFS - 1));
				bad_code      <= 1'b0;
			end else begin
				coef_index    <= cur_q.idx;
				coef_value    <= cur_q.val;
				last_in_block <= (cur_q.idx == 6'(BLOCK_COEFFS - 1)) || cur_q.bad;
				bad_code      <= cur_q.bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end else if (adv) begin
			if (busy_q) begin
				ovalid_q <= 1'b1;
				if (cur_q.zeros == 7'd0 || (cur_q.zeros == 7'd1 && !cur_q.has_val)) begin
					busy_q <= 1'b0;
				end
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/jpeg_block_entropy_decoder_top.sv @@
// Baseline JPEG block entropy decoder: one stream bit per cycle in when not stalled, zigzag coefficients out.
// Table loads and stream bits are taken at one word per cycle, except that intake pauses
// after each matched Huffman code while the symbol memory is read. Zero runs are
// emitted one coefficient per cycle while the receiver is ready, from a four-entry command
// queue, and they hold up intake only when that queue is full.
// Depends on jbed_pkg, jbed_front, jbed_queue, jbed_back.
module jpeg_block_entropy_decoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic              table_sel,
	input  logic [7:0]        entry_index,
	input  logic [7:0]        entry_value,
	input  logic              data_bit,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        coef_index,
	output logic signed [15:0] coef_value,
	output logic              last_in_block,
	output logic              bad_code
);
	import jbed_pkg::*;

	logic q_full;
	logic q_avail;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t q_head;

	jbed_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.table_sel   (table_sel),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.data_bit    (data_bit),
		.q_full      (q_full),
		.push        (q_push),
		.push_cmd    (push_cmd)
	);

	jbed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.avail    (q_avail),
		.head     (q_head)
	);

	jbed_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (q_avail),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.coef_index    (coef_index),
		.coef_value    (coef_value),
		.last_in_block (last_in_block),
		.bad_code      (bad_code)
	);
endmodule

@@ rtl/core/jbed_checker.sv @@
// Port-level checker for the block entropy decoder, bound to the top level.
// Depends on jpeg_block_entropy_decoder_top_defines.svh.
`include "jpeg_block_entropy_decoder_top_defines.svh"

module jbed_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  coef_index,
	input logic [15:0] coef_value,
	input logic        last_in_block,
	input logic        bad_code
);
	`JBED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "word dropped while stalled")
	`JBED_ASSERT_NOW(a_bad_last, out_valid && bad_code, last_in_block, "error word not last")
	`JBED_ASSERT_NOW(a_bad_zero, out_valid && bad_code, coef_value == 16'd0, "error word nonzero")
	`JBED_ASSERT_NOW(a_last_idx, out_valid && last_in_block && !bad_code, coef_index == 6'd63,
		"last word not at end of block")
endmodule

bind jpeg_block_entropy_decoder_top jbed_checker u_jbed_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.coef_index    (coef_index),
	.coef_value    (coef_value),
	.last_in_block (last_in_block),
	.bad_code      (bad_code)
);
